// ----- rtl/core/sts_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the segment text scroller.
// Used by every module under rtl/core but sts_ram; depends on nothing.
package sts_pkg;

    localparam int NUM_TUBES   = 6;
    localparam int MAX_TEXT    = 64;
    localparam int GLYPH_DEPTH = 128;
    localparam int GLYPH_AW    = $clog2(GLYPH_DEPTH);
    localparam int TEXT_AW     = $clog2(MAX_TEXT);
    localparam int CNT_W       = $clog2(MAX_TEXT + 1);
    localparam int PAD_W       = $clog2(NUM_TUBES + NUM_TUBES / 2 + 1);
    localparam int LEN_MAX     = MAX_TEXT + 3 * NUM_TUBES;
    localparam int POS_W       = $clog2(LEN_MAX + NUM_TUBES + 2) + 1;
    localparam int TUBE_W      = (NUM_TUBES > 1) ? $clog2(NUM_TUBES) : 1;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_W       = 16;

    localparam logic [POS_W-1:0]  TUBES_POS = POS_W'(NUM_TUBES);
    localparam logic [PAD_W-1:0]  TUBES_PAD = PAD_W'(NUM_TUBES);
    localparam logic [TUBE_W-1:0] TUBE_TOP  = TUBE_W'(NUM_TUBES - 1);

    localparam logic [7:0] CHAR_M     = 8'h6D;
    localparam logic [7:0] CHAR_N     = 8'h6E;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    localparam logic [1:0] MODE_SCROLL_IN  = 2'd1;
    localparam logic [1:0] MODE_SCROLL_OUT = 2'd2;

    typedef enum logic [2:0] {
        CMD_GLYPH = 3'd0,
        CMD_LOAD  = 3'd1,
        CMD_TICK  = 3'd2,
        CMD_STOP  = 3'd3,
        CMD_ALLON = 3'd4
    } cmd_e_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INTERVAL = 2'd0,
        CFG_MODE     = 2'd1,
        CFG_DIR      = 2'd2,
        CFG_LOOP     = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_ADV0,
        F_ADV1,
        F_ADV2
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_TEXT,
        B_GLYPH,
        B_OUT
    } back_state_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] char_code;
        logic [7:0] pattern;
        logic       last;
    } item_t;

    typedef struct packed {
        logic [7:0] segments;
        logic       end_of_frame;
        logic       scroll_running;
    } result_t;

    typedef struct packed {
        logic             fill;
        logic             fill_ones;
        logic [POS_W-1:0] start;
        logic             running;
    } job_t;

    typedef struct packed {
        logic [PAD_W-1:0] front_pad;
        logic [CNT_W-1:0] text_count;
    } text_view_t;

    typedef struct packed {
        logic               en;
        logic [GLYPH_AW-1:0] addr;
        logic [7:0]         data;
    } glyph_wr_t;

    typedef struct packed {
        logic               en;
        logic [TEXT_AW-1:0] addr;
        logic [7:0]         data;
    } text_wr_t;

    // padded position lands on a stored character
    function automatic logic text_hit(logic [POS_W-1:0] p, logic [PAD_W-1:0] fp,
                                      logic [CNT_W-1:0] tc);
        logic [POS_W-1:0] q;
        begin
            q = p - POS_W'(fp);
            return (p >= POS_W'(fp)) && (q < POS_W'(tc));
        end
    endfunction

    function automatic logic [TEXT_AW-1:0] text_index(logic [POS_W-1:0] p,
                                                      logic [PAD_W-1:0] fp);
        logic [POS_W-1:0] q;
        begin
            q = p - POS_W'(fp);
            return q[TEXT_AW-1:0];
        end
    endfunction

    function automatic logic [7:0] default_glyph(logic [GLYPH_AW-1:0] c);
        logic [7:0] g;
        begin
            unique case (c)
                7'h5F: g = 8'h01;  7'h5E: g = 8'h34;  7'h2D: g = 8'h08;
                7'h5B: g = 8'h17;  7'h5D: g = 8'hB1;  7'h30: g = 8'hB7;
                7'h31: g = 8'hA0;  7'h32: g = 8'h3B;  7'h33: g = 8'hB9;
                7'h34: g = 8'hAC;  7'h35: g = 8'h9D;  7'h36: g = 8'h9F;
                7'h37: g = 8'hB0;  7'h38: g = 8'hBF;  7'h39: g = 8'hBD;
                7'h41: g = 8'hBE;  7'h42: g = 8'h8F;  7'h43: g = 8'h17;
                7'h63: g = 8'h0B;  7'h44: g = 8'hAB;  7'h45: g = 8'h1F;
                7'h46: g = 8'h1E;  7'h47: g = 8'h97;  7'h48: g = 8'hAE;
                7'h49: g = 8'hA0;  7'h69: g = 8'h90;  7'h4A: g = 8'hA3;
                7'h4C: g = 8'h07;  7'h4E: g = 8'hB6;  7'h6E: g = 8'h8A;
                7'h6D: g = 8'hCA;  7'h4F: g = 8'hB7;  7'h6F: g = 8'h8B;
                7'h50: g = 8'h3E;  7'h51: g = 8'hBC;  7'h52: g = 8'h0A;
                7'h72: g = 8'h0A;  7'h53: g = 8'h9D;  7'h54: g = 8'h0F;
                7'h55: g = 8'hA7;  7'h59: g = 8'hAD;  7'h5A: g = 8'h3B;
                7'h21: g = 8'h60;
                default: g = 8'h00;
            endcase
            return g;
        end
    endfunction

endpackage

// ----- rtl/core/segment_text_scroller.sv -----
`timescale 1ns / 1ps
// Top level of the segment text scroller: front end, job queue, back end and
// the two copies of the text store. Depends on sts_pkg and all sts_* modules.
//
//  channel  | handshake                 | payload         | direction
//  ---------+---------------------------+-----------------+----------
//  request  | item_valid / item_stall   | item (item_t)   | in
//  result   | seg_valid / seg_stall     | seg (result_t)  | out
//  config   | cfg_we                    | cfg_index, data | in
//
// A request that makes no frame does not hold the front end; a scroll step holds
// it through F_ADV0, F_ADV1 and F_ADV2 (two text store reads for the look-ahead pair).
// A frame drains tube by tube through a text read, a glyph read and an output load
// (fill jobs skip the reads), paced by the back end's single read ports.
// Glyph writes and character loads wait until the back end is idle.
// Reset clears all control state; the glyph table reads built-in defaults
// until an entry is written. A stalled output holds the back end, not the front.
module segment_text_scroller import sts_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  item_t                item,
    output logic                 seg_valid,
    input  logic                 seg_stall,
    output result_t              seg
);

    job_t               push_job, head_job;
    logic               job_push, q_full, q_empty, pop, back_idle;
    text_wr_t           text_wr;
    glyph_wr_t          glyph_wr;
    text_view_t         view;
    logic [TEXT_AW-1:0] front_raddr, back_raddr;
    logic [7:0]         front_rdata, back_rdata;

    sts_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .q_full       (q_full),
        .q_empty      (q_empty),
        .back_idle    (back_idle),
        .job_push     (job_push),
        .job          (push_job),
        .text_wr      (text_wr),
        .glyph_wr     (glyph_wr),
        .text_rd_addr (front_raddr),
        .text_rd_data (front_rdata),
        .view         (view)
    );

    // front copy of the text store serves the look-ahead reads
    sts_ram #(.WIDTH(8), .DEPTH(MAX_TEXT)) u_text_front (
        .clk   (clk),
        .we    (text_wr.en),
        .waddr (text_wr.addr),
        .wdata (text_wr.data),
        .raddr (front_raddr),
        .rdata (front_rdata)
    );

    // back copy serves frame rendering
    sts_ram #(.WIDTH(8), .DEPTH(MAX_TEXT)) u_text_back (
        .clk   (clk),
        .we    (text_wr.en),
        .waddr (text_wr.addr),
        .wdata (text_wr.data),
        .raddr (back_raddr),
        .rdata (back_rdata)
    );

    sts_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    sts_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (!q_empty),
        .head_job     (head_job),
        .pop          (pop),
        .idle         (back_idle),
        .view         (view),
        .text_rd_addr (back_raddr),
        .text_rd_data (back_rdata),
        .glyph_wr     (glyph_wr),
        .seg_valid    (seg_valid),
        .seg_stall    (seg_stall),
        .seg          (seg)
    );

    // never push into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(job_push && q_full))
        else $error("job pushed into full queue");

    // never pop an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_empty)
        else $error("job popped from empty queue");

    // text and glyph writes only while the back end is drained
    a_write_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (text_wr.en || glyph_wr.en) |-> (q_empty && back_idle))
        else $error("store written while frames pending");

endmodule

// ----- rtl/core/sts_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// ----- rtl/core/sts_front.sv -----
`timescale 1ns / 1ps
// Front end: takes requests and config writes, keeps the scroll state and
// queues frame jobs. Depends on sts_pkg.
module sts_front import sts_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  item_t                item,
    input  logic                 q_full,
    input  logic                 q_empty,
    input  logic                 back_idle,
    output logic                 job_push,
    output job_t                 job,
    output text_wr_t             text_wr,
    output glyph_wr_t            glyph_wr,
    output logic [TEXT_AW-1:0]   text_rd_addr,
    input  logic [7:0]           text_rd_data,
    output text_view_t           view
);

    front_state_t state_reg, state_next;

    logic [15:0]        interval_reg;
    logic [1:0]         mode_reg;
    logic               dir_cfg_reg;
    logic               loop_cfg_reg;
    logic [CNT_W-1:0]   tc_reg, tc_next;
    logic [PAD_W-1:0]   fp_reg, fp_next;
    logic [PAD_W-1:0]   bp_reg, bp_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [15:0]        tick_reg, tick_next;
    logic               active_reg, active_next;
    logic               loop_now_reg, loop_now_next;
    logic               dir_reg, dir_next;
    logic               new_text_reg, new_text_next;
    logic               cond_reg, cond_next;
    logic               a_in_reg, a_in_next;
    logic               b_in_reg, b_in_next;
    logic               a_m_reg, a_m_next;
    logic [TEXT_AW-1:0] b_idx_reg, b_idx_next;

    logic accept, can_take, go_adv;
    logic cmd_glyph, cmd_load, cmd_tick, cmd_stop, cmd_allon;

    // load path
    logic [CNT_W-1:0] tc_base, tc_new;
    logic             store_ok, fits_static, is_auto, short_text;
    logic [PAD_W-1:0] diff, cl, cr, pf, pb;

    // tick path
    logic [15:0] tick_inc;
    logic        due;

    // advance path
    logic [POS_W-1:0] len, a_pos, b_pos, sp1, start_pos;
    logic             cond, skip, at_end;

    assign cmd_glyph = (item.cmd == CMD_GLYPH);
    assign cmd_load  = (item.cmd == CMD_LOAD);
    assign cmd_tick  = (item.cmd == CMD_TICK);
    assign cmd_stop  = (item.cmd == CMD_STOP);
    assign cmd_allon = (item.cmd == CMD_ALLON);

    assign view.front_pad  = fp_reg;
    assign view.text_count = tc_reg;

    // memory writers wait for the back end to drain; frame makers need a slot
    always_comb
    begin
        priority if (cmd_glyph || cmd_load)
            can_take = q_empty && back_idle;
        else if (cmd_tick || cmd_stop || cmd_allon)
            can_take = !q_full;
        else
            can_take = 1'b1;
    end

    assign item_stall = !((state_reg == F_IDLE) && can_take);
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        tc_base     = new_text_reg ? '0 : tc_reg;
        store_ok    = tc_base < CNT_W'(MAX_TEXT);
        tc_new      = tc_base + CNT_W'(store_ok);
        short_text  = POS_W'(tc_new) < TUBES_POS;
        fits_static = POS_W'(tc_new) <= TUBES_POS;
        diff        = short_text ? PAD_W'(TUBES_POS - POS_W'(tc_new)) : '0;
        cl          = diff >> 1;
        cr          = diff - cl;
        is_auto     = !((mode_reg == MODE_SCROLL_IN) || (mode_reg == MODE_SCROLL_OUT));
        fits_static = fits_static && is_auto;
        priority if (is_auto)
        begin
            pf = TUBES_PAD;
            pb = TUBES_PAD;
        end
        else if ((mode_reg == MODE_SCROLL_IN) == !dir_cfg_reg)
        begin
            pf = TUBES_PAD;
            pb = '0;
        end
        else
        begin
            pf = '0;
            pb = TUBES_PAD;
        end
        tick_inc = (tick_reg == 16'hFFFF) ? tick_reg : tick_reg + 16'd1;
        due      = tick_inc >= interval_reg;
        go_adv   = (cmd_load && item.last && !fits_static)
                   || (cmd_tick && active_reg && due);
    end

    // advance: the look-ahead pair and the resulting frame start
    always_comb
    begin
        len = POS_W'(fp_reg) + POS_W'(tc_reg) + POS_W'(bp_reg);
        if (!dir_reg)
        begin
            cond  = (pos_reg + TUBES_POS) < len;
            b_pos = pos_reg + TUBES_POS;
        end
        else
        begin
            cond  = len >= (pos_reg + TUBES_POS + POS_W'(1));
            b_pos = len - pos_reg - TUBES_POS;
        end
        a_pos = b_pos - POS_W'(1);
        skip  = cond_reg && a_m_reg && b_in_reg && (text_rd_data == CHAR_N);
        sp1   = pos_reg + POS_W'(skip);
        if (!dir_reg)
            start_pos = sp1;
        else
            start_pos = (len >= sp1 + TUBES_POS) ? len - sp1 - TUBES_POS : '0;
        at_end = (sp1 + TUBES_POS) >= len;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: if (accept && go_adv) state_next = F_ADV0;
            F_ADV0: state_next = F_ADV1;
            F_ADV1: state_next = F_ADV2;
            F_ADV2: if (!q_full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        job_push       = 1'b0;
        job            = '0;
        text_wr.en     = accept && cmd_load && store_ok;
        text_wr.addr   = tc_base[TEXT_AW-1:0];
        text_wr.data   = item.char_code;
        glyph_wr.en    = accept && cmd_glyph;
        glyph_wr.addr  = item.char_code[GLYPH_AW-1:0];
        glyph_wr.data  = item.pattern;
        text_rd_addr   = b_idx_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    priority if (cmd_load && item.last && fits_static)
                    begin
                        job_push = 1'b1;
                    end
                    else if (cmd_stop)
                    begin
                        job_push  = 1'b1;
                        job.fill  = 1'b1;
                    end
                    else if (cmd_allon)
                    begin
                        job_push      = 1'b1;
                        job.fill      = 1'b1;
                        job.fill_ones = 1'b1;
                        job.running   = active_reg;
                    end
                    else
                    begin
                        job_push = 1'b0;
                    end
                end
            end
            F_ADV0: text_rd_addr = text_index(a_pos, fp_reg);
            F_ADV1: text_rd_addr = b_idx_reg;
            F_ADV2:
            begin
                job_push    = !q_full;
                job.start   = start_pos;
                job.running = !at_end || loop_now_reg;
            end
            default: job_push = 1'b0;
        endcase
    end

    always_comb
    begin
        tc_next       = tc_reg;
        fp_next       = fp_reg;
        bp_next       = bp_reg;
        pos_next      = pos_reg;
        tick_next     = tick_reg;
        active_next   = active_reg;
        loop_now_next = loop_now_reg;
        dir_next      = dir_reg;
        new_text_next = new_text_reg;
        cond_next     = cond_reg;
        a_in_next     = a_in_reg;
        b_in_next     = b_in_reg;
        a_m_next      = a_m_reg;
        b_idx_next    = b_idx_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    priority if (cmd_load)
                    begin
                        if (new_text_reg)
                            active_next = 1'b0;
                        new_text_next = item.last;
                        tc_next       = tc_new;
                        if (item.last)
                        begin
                            if (fits_static)
                            begin
                                fp_next     = cl;
                                bp_next     = cr;
                                active_next = 1'b0;
                            end
                            else
                            begin
                                fp_next       = cl + pf;
                                bp_next       = cr + pb;
                                dir_next      = dir_cfg_reg;
                                loop_now_next = is_auto && loop_cfg_reg;
                                pos_next      = '0;
                                tick_next     = '0;
                                active_next   = 1'b1;
                            end
                        end
                    end
                    else if (cmd_tick && active_reg)
                    begin
                        tick_next = due ? 16'd0 : tick_inc;
                    end
                    else if (cmd_stop)
                    begin
                        active_next = 1'b0;
                        pos_next    = '0;
                    end
                    else
                    begin
                        tick_next = tick_reg;
                    end
                end
            end
            F_ADV0:
            begin
                cond_next  = cond;
                a_in_next  = text_hit(a_pos, fp_reg, tc_reg);
                b_in_next  = text_hit(b_pos, fp_reg, tc_reg);
                b_idx_next = text_index(b_pos, fp_reg);
            end
            F_ADV1:
            begin
                a_m_next = a_in_reg && (text_rd_data == CHAR_M);
            end
            F_ADV2:
            begin
                if (!q_full)
                begin
                    if (at_end)
                    begin
                        pos_next    = '0;
                        active_next = loop_now_reg;
                    end
                    else
                    begin
                        pos_next = sp1 + POS_W'(1);
                    end
                end
            end
            default: tc_next = tc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= F_IDLE;
            interval_reg <= 16'd250;
            mode_reg     <= '0;
            dir_cfg_reg  <= 1'b0;
            loop_cfg_reg <= 1'b0;
            tc_reg       <= '0;
            fp_reg       <= '0;
            bp_reg       <= '0;
            pos_reg      <= '0;
            tick_reg     <= '0;
            active_reg   <= 1'b0;
            loop_now_reg <= 1'b0;
            dir_reg      <= 1'b0;
            new_text_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            tc_reg       <= tc_next;
            fp_reg       <= fp_next;
            bp_reg       <= bp_next;
            pos_reg      <= pos_next;
            tick_reg     <= tick_next;
            active_reg   <= active_next;
            loop_now_reg <= loop_now_next;
            dir_reg      <= dir_next;
            new_text_reg <= new_text_next;
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_INTERVAL: interval_reg <= cfg_data;
                    CFG_MODE:     mode_reg     <= cfg_data[1:0];
                    CFG_DIR:      dir_cfg_reg  <= cfg_data[0];
                    CFG_LOOP:     loop_cfg_reg <= cfg_data[0];
                    default:      loop_cfg_reg <= loop_cfg_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cond_reg  <= cond_next;
        a_in_reg  <= a_in_next;
        b_in_reg  <= b_in_next;
        a_m_reg   <= a_m_next;
        b_idx_reg <= b_idx_next;
    end

endmodule

// ----- rtl/core/sts_queue.sv -----
`timescale 1ns / 1ps
// Two-entry job queue between the front and back ends.
// Depends on sts_pkg for job_t.
module sts_queue import sts_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head_job,
    output logic full,
    output logic empty
);

    job_t       entry_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       head_reg, head_next;
    logic       tail;

    assign tail     = head_reg ^ cnt_reg[0];
    assign full     = cnt_reg[1];
    assign empty    = (cnt_reg == 2'd0);
    assign head_job = entry_reg[head_reg];

    always_comb
    begin
        cnt_next  = cnt_reg + 2'(push) - 2'(pop);
        head_next = head_reg ^ pop;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            head_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            head_reg <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[tail] <= push_job;
        end
    end

endmodule

// ----- rtl/core/sts_back.sv -----
`timescale 1ns / 1ps
// Back end: walks one frame job tube by tube, looks up text and glyph, and
// holds each segment byte in the output register. Depends on sts_pkg, sts_ram.
module sts_back import sts_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  job_t               head_job,
    output logic               pop,
    output logic               idle,
    input  text_view_t         view,
    output logic [TEXT_AW-1:0] text_rd_addr,
    input  logic [7:0]         text_rd_data,
    input  glyph_wr_t          glyph_wr,
    output logic               seg_valid,
    input  logic               seg_stall,
    output result_t            seg
);

    back_state_t state_reg, state_next;

    job_t                job_reg;
    logic [TUBE_W-1:0]   tube_reg;
    logic                hit_reg;
    logic [GLYPH_AW-1:0] gaddr_reg;
    logic [GLYPH_DEPTH-1:0] gvalid_reg;
    logic                out_valid_reg;
    result_t             out_reg;

    logic [POS_W-1:0]    p;
    logic [GLYPH_AW-1:0] gaddr, graddr;
    logic [7:0]          gram_q, value;
    logic                slot_free, load_out, last_tube;

    sts_ram #(.WIDTH(8), .DEPTH(GLYPH_DEPTH)) u_glyph_ram (
        .clk   (clk),
        .we    (glyph_wr.en),
        .waddr (glyph_wr.addr),
        .wdata (glyph_wr.data),
        .raddr (graddr),
        .rdata (gram_q)
    );

    assign p            = job_reg.start + POS_W'(tube_reg);
    assign text_rd_addr = text_index(p, view.front_pad);
    assign gaddr        = hit_reg ? text_rd_data[GLYPH_AW-1:0] : CHAR_SPACE[GLYPH_AW-1:0];
    assign graddr       = (state_reg == B_GLYPH) ? gaddr : gaddr_reg;
    assign slot_free    = !out_valid_reg || !seg_stall;
    assign last_tube    = (tube_reg == '0);
    assign idle         = (state_reg == B_IDLE);
    assign pop          = idle && q_valid;
    assign load_out     = (state_reg == B_OUT) && slot_free;
    assign seg_valid    = out_valid_reg;
    assign seg          = out_reg;

    always_comb
    begin
        if (job_reg.fill)
            value = {8{job_reg.fill_ones}};
        else if (gvalid_reg[gaddr_reg])
            value = gram_q;
        else
            value = default_glyph(gaddr_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:  if (q_valid) state_next = head_job.fill ? B_OUT : B_TEXT;
            B_TEXT:  state_next = B_GLYPH;
            B_GLYPH: state_next = B_OUT;
            B_OUT:
            begin
                if (slot_free)
                begin
                    if (last_tube)
                        state_next = B_IDLE;
                    else
                        state_next = job_reg.fill ? B_OUT : B_TEXT;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            gvalid_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!seg_stall)
                out_valid_reg <= 1'b0;
            if (glyph_wr.en)
                gvalid_reg[glyph_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg  <= head_job;
            tube_reg <= TUBE_TOP;
        end
        if (state_reg == B_TEXT)
            hit_reg <= text_hit(p, view.front_pad, view.text_count);
        if (state_reg == B_GLYPH)
            gaddr_reg <= gaddr;
        if (load_out)
        begin
            out_reg.segments       <= value;
            out_reg.end_of_frame   <= last_tube;
            out_reg.scroll_running <= job_reg.running;
            tube_reg               <= tube_reg - TUBE_W'(1);
        end
    end

endmodule
